FILE: src/tli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants for the table interpolator
// Holds the word types of both channels, the command and status codes, and
// the state encoding of the query sequencer.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         entry_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] query_value;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_CHECK,
    ST_SCAN,
    ST_RD_PAIR,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/tli_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_table: sample point memory
// Two synchronous memories, abscissa and value, one write port and one read
// port each, read data registered.
// ----------------------------------------------------------------------------
module tli_table #(
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic signed [31:0]  wr_x,
  input  logic signed [31:0]  wr_y,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic signed [31:0]  rd_x,
  output logic signed [31:0]  rd_y
);

  logic signed [31:0] mem_x [2**ADDR_W];
  logic signed [31:0] mem_y [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

endmodule

FILE: src/tli_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_divider: unsigned restoring divider
// Divides a 64-bit magnitude by a 33-bit magnitude, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module tli_divider (
  input  logic              clk,
  input  logic              rst,
  input  tli_pkg::div_req_t req,
  output tli_pkg::div_rsp_t rsp
);

  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] trial;
  logic [34:0] diff;

  always_comb begin
    trial = {rem[32:0], quo[63]};
    diff  = {1'b0, trial} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!diff[34]) begin
          rem <= diff[33:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

FILE: src/table_linear_interpolator_core.sv
`timescale 1ns / 1ps
// A load is written to the table as it is taken. A query reads the first and last
// entries, then scans the table for its interval, or reads the end pair when
// extrapolating, and runs the serial divide; a zero-width interval skips the divide,
// and so does a query on the last point. No new word is taken while a query is in
// progress; the next word is taken in the cycle after the result word is loaded.
// Reset is synchronous, active high; it sets point_count to 2, not the table.
// ----------------------------------------------------------------------------
// table_linear_interpolator_core: piecewise linear interpolator
// Loads sample points into a table and answers queries by interpolation or
// linear extrapolation, Q16.16 fixed point, with saturation.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tli_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tli_pkg::out_word_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tli_pkg::state_t state, state_next;

  logic [6:0]          point_count;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       rd_addr;
  logic signed [31:0]  rd_x, rd_y;
  logic signed [31:0]  q;
  logic signed [31:0]  x0, y0, xl, yl, px, py;
  logic signed [32:0]  dq, dy, dx;
  logic signed [31:0]  base_y, low_y;
  logic                neg;
  logic [34:0]         qclip;
  logic signed [36:0]  sum;
  logic                wr_en;
  tli_pkg::div_req_t   dreq;
  tli_pkg::div_rsp_t   drsp;
  logic [CW-1:0]       n_eff;
  logic [31:0]         mdq, mdy;
  logic [32:0]         mdx;
  logic                out_load;
  logic                on_last;
  logic                extrap_mode;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) point_count <= 7'd2;
    else if (cfg_valid) point_count <= cfg_data;
  end

  // Clamp the count to 2..TABLE_DEPTH.
  always_comb begin
    if (point_count < 7'd2) n_eff = CW'(2);
    else if (32'(point_count) > 32'(TABLE_DEPTH)) n_eff = CW'(TABLE_DEPTH);
    else n_eff = CW'(point_count);
    last_idx = AW'(n_eff - CW'(1));
  end

  // A finished result waits in the output state while the previous word is
  // still held by the receiver.
  assign out_load = (state == tli_pkg::ST_OUT) && !(out_valid && out_stall);

  assign in_stall = (state != tli_pkg::ST_IDLE);
  assign wr_en = in_valid && !in_stall && (in_data.cmd == tli_pkg::CMD_LOAD)
                 && ({26'd0, in_data.entry_index} < 32'(TABLE_DEPTH));

  tli_table #(.ADDR_W(AW)) u_table (
    .clk, .wr_en, .wr_addr(AW'(in_data.entry_index)),
    .wr_x(in_data.point_x), .wr_y(in_data.point_y),
    .rd_addr, .rd_x, .rd_y
  );

  tli_divider u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  // Differences of two 32-bit values have magnitudes below 2^32.
  always_comb begin
    mdq = dq[32] ? 32'(-dq) : dq[31:0];
    mdy = dy[32] ? 32'(-dy) : dy[31:0];
    mdx = dx[32] ? 33'(-dx) : 33'(dx);
  end

  always_comb begin
    state_next = state;
    rd_addr = idx;
    dreq.start = 1'b0;
    dreq.dividend = 64'(mdq) * 64'(mdy);
    dreq.divisor = mdx;
    unique case (state)
      tli_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (in_valid && !in_stall && in_data.cmd == tli_pkg::CMD_QUERY)
          state_next = tli_pkg::ST_RD_FIRST;
      end
      tli_pkg::ST_RD_FIRST: begin
        rd_addr = last_idx;
        state_next = tli_pkg::ST_RD_LAST;
      end
      tli_pkg::ST_RD_LAST: begin
        rd_addr = AW'(1);
        state_next = tli_pkg::ST_CHECK;
      end
      tli_pkg::ST_CHECK: begin
        // rd holds entry 1; x0 and xl are loaded.
        if (q < x0 || q > xl) state_next = tli_pkg::ST_RD_PAIR;
        else state_next = tli_pkg::ST_SCAN;
        rd_addr = (q > xl && !(q < x0)) ? AW'(last_idx - AW'(1)) : AW'(1);
      end
      tli_pkg::ST_SCAN: begin
        rd_addr = AW'(idx + AW'(1));
        if (q < rd_x) state_next = tli_pkg::ST_MUL;
        else if (idx == last_idx) state_next = tli_pkg::ST_SUM;
      end
      tli_pkg::ST_RD_PAIR: state_next = tli_pkg::ST_MUL;
      tli_pkg::ST_MUL: begin
        if (dx == '0) state_next = tli_pkg::ST_SUM;
        else begin
          dreq.start = 1'b1;
          state_next = tli_pkg::ST_DIV;
        end
      end
      tli_pkg::ST_DIV: if (drsp.done) state_next = tli_pkg::ST_SUM;
      tli_pkg::ST_SUM: state_next = tli_pkg::ST_OUT;
      tli_pkg::ST_OUT: if (out_load) state_next = tli_pkg::ST_IDLE;
      default: state_next = tli_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tli_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Registered datapath: px/py hold the previous scanned entry.
  always_ff @(posedge clk) begin
    unique case (state)
      tli_pkg::ST_IDLE: q <= in_data.query_x;
      tli_pkg::ST_RD_FIRST: begin
        x0 <= rd_x;
        y0 <= rd_y;
      end
      tli_pkg::ST_RD_LAST: begin
        xl <= rd_x;
        yl <= rd_y;
      end
      tli_pkg::ST_CHECK: begin
        extrap_mode <= (q < x0);
        if (q < x0) begin
          // Line through entries 0 and 1, based at entry 0.
          base_y <= y0; low_y <= y0;
          dq <= 33'(q) - 33'(x0);
          dy <= 33'(rd_y) - 33'(y0);
          dx <= 33'(rd_x) - 33'(x0);
        end
        px <= x0; py <= y0;
        idx <= AW'(1);
        on_last <= 1'b0;
      end
      tli_pkg::ST_SCAN: begin
        if (q < rd_x) begin
          base_y <= py; low_y <= py;
          dq <= 33'(q) - 33'(px);
          dy <= 33'(rd_y) - 33'(py);
          dx <= 33'(rd_x) - 33'(px);
        end else begin
          px <= rd_x; py <= rd_y;
          idx <= AW'(idx + AW'(1));
          if (idx == last_idx) begin
            // Query on the last point: the sum path carries its value plus 0.
            base_y <= rd_y;
            qclip <= '0;
            neg <= 1'b0;
            on_last <= 1'b1;
          end
        end
      end
      tli_pkg::ST_RD_PAIR: begin
        if (!extrap_mode) begin
          // rd holds entry e-1; line based at last entry.
          base_y <= yl; low_y <= rd_y;
          dq <= 33'(q) - 33'(xl);
          dy <= 33'(yl) - 33'(rd_y);
          dx <= 33'(xl) - 33'(rd_x);
        end
      end
      tli_pkg::ST_MUL: neg <= (dq[32] ^ dy[32]) ^ dx[32];
      tli_pkg::ST_DIV: begin
        qclip <= (drsp.quotient > 64'h4_0000_0000) ? 35'h4_0000_0000
                                                  : drsp.quotient[34:0];
      end
      tli_pkg::ST_SUM: begin
        sum <= neg ? 37'(base_y) - 37'(qclip) : 37'(base_y) + 37'(qclip);
      end
      tli_pkg::ST_OUT: begin
        if (out_load) begin
          if (dx == '0 && !on_last) begin
            out_data.query_value <= low_y;
            out_data.status <= tli_pkg::STATUS_ZERO;
          end else if (sum > 37'sh0_7FFF_FFFF) begin
            out_data.query_value <= 32'sh7FFF_FFFF;
            out_data.status <= tli_pkg::STATUS_SAT;
          end else if (sum < -37'sh0_8000_0000) begin
            out_data.query_value <= 32'sh8000_0000;
            out_data.status <= tli_pkg::STATUS_SAT;
          end else begin
            out_data.query_value <= sum[31:0];
            out_data.status <= tli_pkg::STATUS_OK;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
